// ===== sv/csl_pkg.sv =====
package csl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_OP,
    MODE_ERR
  } mode_t;

  typedef enum logic [3:0] {
    K_EOF    = 4'd0,
    K_NUM    = 4'd1,
    K_IDENT  = 4'd2,
    K_RETURN = 4'd3,
    K_IF     = 4'd4,
    K_ELSE   = 4'd5,
    K_WHILE  = 4'd6,
    K_FOR    = 4'd7,
    K_INT    = 4'd8,
    K_SIZEOF = 4'd9,
    K_EQ     = 4'd10,
    K_NE     = 4'd11,
    K_LE     = 4'd12,
    K_GE     = 4'd13,
    K_PUNCT  = 4'd14,
    K_ERROR  = 4'd15
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] value;
    logic [15:0] start_pos;
    logic [15:0] length;
    logic        overflow;
    logic        last;
  } token_t;

  // Up to two tokens produced by one character, in emission order.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  localparam int Q_DEPTH = 4;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  localparam int KW_COUNT = 7;

  // Keyword text packed with the first character in the low byte.
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h6E72_7574_6572,  // return
    48'h0000_0000_6669,  // if
    48'h0000_6573_6C65,  // else
    48'h0065_6C69_6877,  // while
    48'h0000_0072_6F66,  // for
    48'h0000_0074_6E69,  // int
    48'h666F_657A_6973   // sizeof
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd3, 3'd6
  };

  localparam kind_t KW_KIND [KW_COUNT] = '{
    K_RETURN, K_IF, K_ELSE, K_WHILE, K_FOR, K_INT, K_SIZEOF
  };

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_lower(c) || is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
           (c == 8'h28) || (c == 8'h29) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_EQ) || (c == 8'h3B) || (c == 8'h7B) || (c == 8'h7D) ||
           (c == 8'h2C) || (c == 8'h26);
  endfunction

endpackage

// ===== sv/csl_in_if.sv =====
interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       text_end;

  modport source (output valid, ch, text_end, input ready);
  modport sink   (input valid, ch, text_end, output ready);
endinterface

// ===== sv/csl_out_if.sv =====
interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [30:0] value;
  logic [15:0] start_pos;
  logic [15:0] length;
  logic        overflow;
  logic        last;

  modport source (output valid, kind, value, start_pos, length, overflow, last,
                  input ready);
  modport sink   (input valid, kind, value, start_pos, length, overflow, last,
                  output ready);
endinterface

// ===== sv/csl_lexer.sv =====
module csl_lexer #(
  parameter int TEXT_BYTES  = 65536,
  parameter int KEYWORD_MAX = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  logic [7:0]     ch,
  input  logic           text_end,
  output csl_pkg::push_t push
);
  import csl_pkg::*;

  localparam int POS_W    = $clog2(TEXT_BYTES);
  localparam int PREFIX_W = 8 * KEYWORD_MAX;

  mode_t               mode, mode_next;
  logic [POS_W-1:0]    position, position_next;
  logic [PREFIX_W-1:0] word_prefix, word_prefix_next;
  logic [15:0]         token_start, token_start_next;
  logic [15:0]         token_length, token_length_next;
  logic [30:0]         number_acc, number_acc_next;
  logic                number_sat, number_sat_next;
  logic [7:0]          pending_op, pending_op_next;

  kind_t               word_kind;
  logic [POS_W+15:0]   pos_ext;
  logic [15:0]         pos16;
  logic [POS_W-1:0]    pos_inc;
  logic [15:0]         len_inc;
  logic [34:0]         acc_wide;
  token_t              flush_tok;
  logic                flush_has;
  logic                flush_err;
  token_t              tok_a, tok_b;
  logic                has_a, has_b;

  assign pos_ext = {16'b0, position};
  assign pos16   = pos_ext[15:0];
  assign pos_inc = (position == POS_W'(TEXT_BYTES - 1)) ? '0 : position + 1'b1;
  assign len_inc = (token_length == 16'hFFFF) ? token_length : token_length + 16'd1;
  // acc * 10 + digit, as two shifted adds.
  assign acc_wide = ({4'b0, number_acc} << 3) + ({4'b0, number_acc} << 1) +
                    35'(ch[3:0]);

  always_comb begin
    word_kind = K_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((token_length == 16'(KW_LEN[k])) &&
          (word_prefix == PREFIX_W'(KW_TEXT[k]))) begin
        word_kind = KW_KIND[k];
      end
    end
  end

  // Token held by the current mode, emitted when something ends it.
  always_comb begin
    flush_tok = '0;
    flush_has = 1'b0;
    flush_err = 1'b0;
    unique case (mode)
      MODE_WORD: begin
        flush_has           = 1'b1;
        flush_tok.kind      = word_kind;
        flush_tok.start_pos = token_start;
        flush_tok.length    = token_length;
      end
      MODE_NUM: begin
        flush_has           = 1'b1;
        flush_tok.kind      = K_NUM;
        flush_tok.value     = number_acc;
        flush_tok.start_pos = token_start;
        flush_tok.length    = token_length;
        flush_tok.overflow  = number_sat;
      end
      MODE_OP: begin
        flush_has           = 1'b1;
        flush_tok.value     = 31'(pending_op);
        flush_tok.start_pos = token_start;
        flush_tok.length    = 16'd1;
        if (pending_op == CH_BANG) begin
          flush_err      = 1'b1;
          flush_tok.kind = K_ERROR;
        end else begin
          flush_tok.kind = K_PUNCT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_next         = mode;
    position_next     = position;
    word_prefix_next  = word_prefix;
    token_start_next  = token_start;
    token_length_next = token_length;
    number_acc_next   = number_acc;
    number_sat_next   = number_sat;
    pending_op_next   = pending_op;
    tok_a = '0;
    tok_b = '0;
    has_a = 1'b0;
    has_b = 1'b0;

    priority if (mode == MODE_ERR) begin
      // Once an error has been seen, every item repeats it.
      has_a           = 1'b1;
      tok_a.kind      = K_ERROR;
      tok_a.value     = 31'(pending_op);
      tok_a.start_pos = token_start;
      tok_a.length    = 16'd1;
    end else if (text_end) begin
      if (flush_err) begin
        has_a     = 1'b1;
        tok_a     = flush_tok;
        mode_next = MODE_ERR;
      end else begin
        has_a           = flush_has;
        tok_a           = flush_tok;
        has_b           = 1'b1;
        tok_b.kind      = K_EOF;
        tok_b.start_pos = pos16;
        mode_next       = MODE_IDLE;
        position_next   = '0;
      end
    end else begin
      position_next = pos_inc;
      priority if ((mode == MODE_WORD) && is_word_char(ch)) begin
        for (int i = 0; i < KEYWORD_MAX; i++) begin
          if (token_length == 16'(i)) begin
            word_prefix_next[8*i +: 8] = ch;
          end
        end
        token_length_next = len_inc;
      end else if ((mode == MODE_NUM) && is_digit(ch)) begin
        if (acc_wide[34:31] != 4'd0) begin
          number_acc_next = NUM_MAX;
          number_sat_next = 1'b1;
        end else begin
          number_acc_next = acc_wide[30:0];
        end
        token_length_next = len_inc;
      end else if ((mode == MODE_OP) && (ch == CH_EQ)) begin
        has_a           = 1'b1;
        tok_a.start_pos = token_start;
        tok_a.length    = 16'd2;
        priority if (pending_op == CH_EQ) begin
          tok_a.kind = K_EQ;
        end else if (pending_op == CH_BANG) begin
          tok_a.kind = K_NE;
        end else if (pending_op == CH_LT) begin
          tok_a.kind = K_LE;
        end else begin
          tok_a.kind = K_GE;
        end
        mode_next = MODE_IDLE;
      end else if (flush_err) begin
        has_a     = 1'b1;
        tok_a     = flush_tok;
        mode_next = MODE_ERR;
      end else begin
        has_a             = flush_has;
        tok_a             = flush_tok;
        mode_next         = MODE_IDLE;
        token_start_next  = pos16;
        token_length_next = 16'd1;
        priority if (is_space(ch)) begin
          mode_next = MODE_IDLE;
        end else if (is_lower(ch)) begin
          mode_next        = MODE_WORD;
          word_prefix_next = PREFIX_W'(ch);
        end else if (is_digit(ch)) begin
          mode_next       = MODE_NUM;
          number_acc_next = 31'(ch[3:0]);
          number_sat_next = 1'b0;
        end else if ((ch == CH_EQ) || (ch == CH_BANG) || (ch == CH_LT) ||
                     (ch == CH_GT)) begin
          mode_next       = MODE_OP;
          pending_op_next = ch;
        end else if (is_punct(ch)) begin
          has_b           = 1'b1;
          tok_b.kind      = K_PUNCT;
          tok_b.value     = 31'(ch);
          tok_b.start_pos = pos16;
          tok_b.length    = 16'd1;
        end else begin
          mode_next       = MODE_ERR;
          pending_op_next = ch;
          has_b           = 1'b1;
          tok_b.kind      = K_ERROR;
          tok_b.value     = 31'(ch);
          tok_b.start_pos = pos16;
          tok_b.length    = 16'd1;
        end
      end
    end

    push.first  = has_a ? tok_a : tok_b;
    push.second = tok_b;
    push.count  = go ? (2'(has_a) + 2'(has_b)) : 2'd0;
    if (has_a && has_b) begin
      push.second.last = 1'b1;
    end else begin
      push.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      position <= '0;
    end else if (go) begin
      mode     <= mode_next;
      position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      word_prefix  <= word_prefix_next;
      token_start  <= token_start_next;
      token_length <= token_length_next;
      number_acc   <= number_acc_next;
      number_sat   <= number_sat_next;
      pending_op   <= pending_op_next;
    end
  end

endmodule

// ===== sv/csl_out_queue.sv =====
module csl_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  csl_pkg::push_t push,
  output logic           room,
  csl_out_if.source      tokens
);
  import csl_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  token_t           entries [Q_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W:0]   fill;
  logic             pop;
  token_t           head;

  assign pop  = tokens.valid && tokens.ready;
  assign head = entries[rd_ptr];
  // Leave space for the two tokens one character can produce.
  assign room = (fill <= (PTR_W + 1)'(Q_DEPTH - 2));

  assign tokens.valid     = (fill != '0);
  assign tokens.kind      = head.kind;
  assign tokens.value     = head.value;
  assign tokens.start_pos = head.start_pos;
  assign tokens.length    = head.length;
  assign tokens.overflow  = head.overflow;
  assign tokens.last      = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr + PTR_W'(pop);
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      fill   <= fill + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

endmodule

// ===== sv/c_subset_lexer_top.sv =====
// Streaming tokenizer for a small C subset.
// The text channel takes one source byte per transfer (ch), or an end mark
// (text_end = 1) that flushes any pending token and produces an EOF token.
// The tokens channel delivers kind, value, start_pos, length and overflow;
// last marks the final token caused by one input transfer.
// An accepted byte is held in an input register and is lexed from there
// once the result queue has room for two tokens; its tokens are then
// registered into the four-entry result queue, whose oldest token is offered.
// Throughput is one byte per cycle while the queue has room. A byte that
// ends one token and forms another yields two tokens; the single output
// port then limits the rate to one token per cycle, and input ready drops
// while a byte waits in the input register and the queue has fewer than
// two free entries.
// When the receiver stalls the queue fills and input ready falls; nothing is
// lost or repeated. A lexing error is sticky: each later transfer returns
// the same error token until reset.
// Reset (synchronous, active high) empties the queue, clears the input
// register, returns the lexer to idle and sets the text position to zero.
module c_subset_lexer_top #(
  parameter int TEXT_BYTES  = 65536,
  parameter int KEYWORD_MAX = 6
) (
  input  logic      clk,
  input  logic      rst,
  csl_in_if.sink    text,
  csl_out_if.source tokens
);
  import csl_pkg::*;

  logic       q_valid;
  logic [7:0] q_ch;
  logic       q_end;
  logic       room;
  logic       go;
  push_t      push;

  assign go         = q_valid && room;
  assign text.ready = !q_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (text.ready) begin
      q_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      q_ch  <= text.ch;
      q_end <= text.text_end;
    end
  end

  csl_lexer #(
    .TEXT_BYTES  (TEXT_BYTES),
    .KEYWORD_MAX (KEYWORD_MAX)
  ) u_lexer (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .ch       (q_ch),
    .text_end (q_end),
    .push     (push)
  );

  csl_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

`ifndef SYNTHESIS
  a_push_only_when_lexing: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> go)
    else $error("tokens pushed without a character being lexed");

  a_pair_marks_second_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.second.last && !push.first.last))
    else $error("token pair has last on the wrong entry");

  a_group_stays_together: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.ready && !tokens.last) |=> tokens.valid)
    else $error("second token of a pair missing after the first transfer");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import csl_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       text_end;
    bit         drain;
  } text_item_t;

  // Only the first six characters of a word are kept for keyword matching.
  localparam int KW_KEEP = 6;
  localparam logic [47:0] KW_WORDS [KW_COUNT] = '{
    "return", "if", "else", "while", "for", "int", "sizeof"
  };
  localparam int KW_LENS [KW_COUNT] = '{6, 2, 4, 5, 3, 3, 6};
  localparam kind_t KW_KINDS [KW_COUNT] = '{
    K_RETURN, K_IF, K_ELSE, K_WHILE, K_FOR, K_INT, K_SIZEOF
  };

  logic clk;
  logic rst;

  csl_in_if  text_if ();
  csl_out_if tokens_if ();

  c_subset_lexer_top DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .tokens (tokens_if)
  );

  text_item_t text_items[$];
  token_t     step_tokens[$];
  token_t     expected_tokens[$];
  int         items_total;
  int         items_taken;
  int         mismatches;
  logic       steady;

  // Lexer state as predicted from the accepted text.
  mode_t       lx_mode;
  logic [47:0] word_bits;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] text_pos;
  logic [30:0] num_acc;
  logic        num_sat;
  logic [7:0]  held_op;
  logic        err_seen;

  assign steady = (items_taken >= 200) && (items_taken < 550);

  function automatic bit is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic bit is_low(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return is_low(c) || is_dig(c) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic bit is_op_lead(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic bit is_single_punct(input logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "(", ")", "<", ">", "=", ";", "{", "}", ",", "&": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit token_ok(input logic [7:0] c);
    return is_ws(c) || is_low(c) || is_dig(c) || is_op_lead(c) || is_single_punct(c);
  endfunction

  function automatic kind_t word_kind();
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((tok_len == KW_LENS[k]) && (word_bits == KW_WORDS[k])) return KW_KINDS[k];
    end
    return K_IDENT;
  endfunction

  task automatic note_token(input kind_t k, input logic [30:0] v, input logic [15:0] s,
                            input logic [15:0] n, input logic o);
    token_t t;
    t.kind = k;
    t.value = v;
    t.start_pos = s;
    t.length = n;
    t.overflow = o;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic fail_at(input logic [7:0] c, input logic [15:0] at);
    err_seen = 1'b1;
    lx_mode = MODE_ERR;
    held_op = c;
    tok_start = at;
    note_token(K_ERROR, {23'd0, c}, at, 16'd1, 1'b0);
  endtask

  // Emits whatever token is pending; ok drops when a lone '!' turns into an error.
  task automatic close_token(output bit ok);
    ok = 1'b1;
    case (lx_mode)
      MODE_WORD: note_token(word_kind(), 31'd0, tok_start, tok_len, 1'b0);
      MODE_NUM: note_token(K_NUM, num_acc, tok_start, tok_len, num_sat);
      MODE_OP: begin
        if (held_op == CH_BANG) begin
          fail_at(CH_BANG, tok_start);
          ok = 1'b0;
        end else begin
          note_token(K_PUNCT, {23'd0, held_op}, tok_start, 16'd1, 1'b0);
        end
      end
      default: ;
    endcase
    if (ok) lx_mode = MODE_IDLE;
  endtask

  task automatic lex_step(input logic [7:0] c, input logic eot);
    bit          ok;
    logic [34:0] grown;
    token_t      t;
    step_tokens.delete();
    if (err_seen) begin
      note_token(K_ERROR, {23'd0, held_op}, tok_start, 16'd1, 1'b0);
    end else if (eot) begin
      close_token(ok);
      if (ok) begin
        note_token(K_EOF, 31'd0, text_pos, 16'd0, 1'b0);
        text_pos = 16'd0;
      end
    end else begin
      if ((lx_mode == MODE_WORD) && word_char(c)) begin
        if (tok_len < KW_KEEP) word_bits = {word_bits[39:0], c};
        if (tok_len != 16'hFFFF) tok_len++;
      end else if ((lx_mode == MODE_NUM) && is_dig(c)) begin
        grown = 35'(num_acc) * 35'd10 + 35'(c) - 35'h30;
        if (grown > 35'(NUM_MAX)) begin
          num_acc = NUM_MAX;
          num_sat = 1'b1;
        end else begin
          num_acc = grown[30:0];
        end
        if (tok_len != 16'hFFFF) tok_len++;
      end else if ((lx_mode == MODE_OP) && (c == CH_EQ)) begin
        note_token(held_op == CH_EQ ? K_EQ : held_op == CH_BANG ? K_NE :
                   held_op == CH_LT ? K_LE : K_GE, 31'd0, tok_start, 16'd2, 1'b0);
        lx_mode = MODE_IDLE;
      end else begin
        close_token(ok);
        if (ok) begin
          lx_mode = MODE_IDLE;
          tok_start = text_pos;
          tok_len = 16'd1;
          if (is_ws(c)) begin
          end else if (is_low(c)) begin
            lx_mode = MODE_WORD;
            word_bits = {40'd0, c};
          end else if (is_dig(c)) begin
            lx_mode = MODE_NUM;
            num_acc = 31'(c - 8'h30);
            num_sat = 1'b0;
          end else if (is_op_lead(c)) begin
            lx_mode = MODE_OP;
            held_op = c;
          end else if (is_single_punct(c)) begin
            note_token(K_PUNCT, {23'd0, c}, text_pos, 16'd1, 1'b0);
          end else begin
            fail_at(c, text_pos);
          end
        end
      end
      // The 16-bit position wraps exactly at the text size.
      text_pos++;
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  task automatic add_item(input logic [7:0] c, input logic eot, input bit hold);
    text_item_t it;
    it.ch = c;
    it.text_end = eot;
    it.drain = hold;
    text_items.push_back(it);
    if (!hold) items_total++;
  endtask

  // The byte of an end mark is ignored, so it carries any value.
  task automatic add_end();
    add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] word_tail();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  task automatic add_token();
    int    sel;
    int    k;
    int    n;
    string leads;
    string puncts;
    string noise;
    leads = "=!<>";
    puncts = "+-*/()<>=;{},&";
    noise = "az09=<>+;( ";
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      k = $urandom_range(0, KW_COUNT - 1);
      for (int i = KW_LENS[k] - 1; i >= 0; i--) add_item(KW_WORDS[k][8*i +: 8], 1'b0, 1'b0);
      if ($urandom_range(0, 3) == 0) add_item(word_tail(), 1'b0, 1'b0);
    end else if (sel < 35) begin
      add_item(8'("a" + $urandom_range(0, 25)), 1'b0, 1'b0);
      n = $urandom_range(0, 7);
      repeat (n) add_item(word_tail(), 1'b0, 1'b0);
    end else if (sel < 50) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
      repeat (n) add_item(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0);
    end else if (sel < 60) begin
      // A '!' is always followed by '=' so that no error is raised here.
      add_item(leads[$urandom_range(0, 3)], 1'b0, 1'b0);
      add_item(CH_EQ, 1'b0, 1'b0);
    end else if (sel < 75) begin
      add_item(puncts[$urandom_range(0, 13)], 1'b0, 1'b0);
    end else if (sel < 90) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        k = $urandom_range(8, 13);
        add_item((k == 8) ? 8'd32 : 8'(k), 1'b0, 1'b0);
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_item(noise[$urandom_range(0, noise.len() - 1)], 1'b0, 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [30:0] want,
                             input logic [30:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    text_if.valid = 1'b0;
    text_if.ch = 8'd0;
    text_if.text_end = 1'b0;
    tokens_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Sender: one transfer per accepted item, with random gaps outside the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      text_if.valid <= 1'b0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        lex_step(text_if.ch, text_if.text_end);
        items_taken++;
      end
      if (!text_if.valid || text_if.ready) begin
        if ((text_items.size() != 0) && !text_items[0].drain &&
            (steady || ($urandom_range(0, 99) >= 35))) begin
          text_if.valid <= 1'b1;
          text_if.ch <= text_items[0].ch;
          text_if.text_end <= text_items[0].text_end;
          void'(text_items.pop_front());
        end else begin
          if ((text_items.size() != 0) && text_items[0].drain &&
              (expected_tokens.size() == 0))
            void'(text_items.pop_front());
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every token transfer against the oldest prediction.
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      if (tokens_if.valid && tokens_if.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: no token expected, got kind %0d value %0d at %0d", $time,
                   tokens_if.kind, tokens_if.value, tokens_if.start_pos);
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", 31'(want.kind), 31'(tokens_if.kind));
          check_field("value", want.value, tokens_if.value);
          check_field("start_pos", 31'(want.start_pos), 31'(tokens_if.start_pos));
          check_field("length", 31'(want.length), 31'(tokens_if.length));
          check_field("overflow", 31'(want.overflow), 31'(tokens_if.overflow));
          check_field("last", 31'(want.last), 31'(tokens_if.last));
        end
      end
      tokens_if.ready <= steady || ($urandom_range(0, 99) >= 35);
    end
  end

  initial begin
    int         n;
    logic [7:0] c;
    items_total = 0;
    items_taken = 0;
    mismatches = 0;
    lx_mode = MODE_IDLE;
    word_bits = 48'd0;
    tok_start = 16'd0;
    tok_len = 16'd0;
    text_pos = 16'd0;
    num_acc = 31'd0;
    num_sat = 1'b0;
    held_op = 8'd0;
    err_seen = 1'b0;

    // Saturating number, the pairs >=, == and !=, and a '<' flushed by the end mark.
    add_text("if(x_Z>=99999999999)y==z!=w<");
    add_end();
    add_end();
    add_item(8'd0, 1'b1, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0);
    add_item(8'd0, 1'b0, 1'b1);

    while (items_total < 1300) begin
      n = $urandom_range(0, 30);
      repeat (n) add_token();
      add_end();
      if ($urandom_range(0, 5) == 0) add_item(8'd0, 1'b0, 1'b1);
    end

    // The run ends with one error; it stays sticky until the end.
    case ($urandom_range(0, 2))
      0: begin
        add_text("ab");
        c = 8'($urandom_range(0, 255));
        while (token_ok(c)) c = 8'($urandom_range(0, 255));
        add_item(c, 1'b0, 1'b0);
      end
      1: begin
        add_text("x!");
        c = 8'($urandom_range(0, 255));
        while (c == CH_EQ) c = 8'($urandom_range(0, 255));
        add_item(c, 1'b0, 1'b0);
      end
      default: begin
        add_text("x !");
        add_end();
      end
    endcase
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) add_end();
      else add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (items_taken != items_total) @(negedge clk);
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
